@@ design/tcos_pkg.sv @@
// Shared types, constants and state encodings for the fixed-point cosine series block.
package tcos_pkg;

  // Build-time sizing of the series engine
  localparam int MAX_TERMS  = 1024;
  localparam int FRAC_BITS  = 28;

  // Field widths of the request and response
  localparam int ANGLE_W    = 32;
  localparam int THR_W      = 32;
  localparam int TERMS_W    = 11;

  // Internal term and sum format: signed Q23.40
  localparam int ACC_W      = 64;
  localparam int ACC_FRAC   = 40;
  localparam int THR_SHIFT  = ACC_FRAC - THR_W;
  localparam int OUT_SHIFT  = ACC_FRAC - FRAC_BITS;
  localparam logic [ACC_W-1:0] ACC_ONE = ACC_W'(1) << ACC_FRAC;
  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Output clamp bounds in the widened sum format
  localparam logic signed [ACC_W-1:0] RES_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] RES_LO = 64'shFFFF_FFFF_8000_0000;
  localparam logic [ANGLE_W-1:0] COS_HI = 32'h7FFF_FFFF;
  localparam logic [ANGLE_W-1:0] COS_LO = 32'h8000_0000;

  // Term counter and series divisor (2n-1)(2n)
  localparam int CNT_W      = $clog2(MAX_TERMS + 1);
  localparam int D_MAX      = (2 * MAX_TERMS - 1) * (2 * MAX_TERMS);
  localparam int D_W        = $clog2(D_MAX + 1);

  // Shared 32x32 multiplier and the 128-bit product it builds
  localparam int MUL_W      = 32;
  localparam int PROD_W     = 2 * ACC_W;
  localparam int MUL_STEP_W = 3;
  localparam logic [MUL_STEP_W-1:0] MUL_PP0  = 3'd0;
  localparam logic [MUL_STEP_W-1:0] MUL_PP1  = 3'd1;
  localparam logic [MUL_STEP_W-1:0] MUL_PP2  = 3'd2;
  localparam logic [MUL_STEP_W-1:0] MUL_PP3  = 3'd3;
  localparam logic [MUL_STEP_W-1:0] MUL_DIV  = 3'd4;
  localparam logic [MUL_STEP_W-1:0] MUL_LAST = 3'd5;

  // Long division: 63 quotient bits, a few per cycle
  localparam int QUO_W      = ACC_W - 1;
  localparam int QSH        = 2 * FRAC_BITS + QUO_W;
  localparam int DIV_STEP   = 3;
  localparam int DIV_CYCLES = QUO_W / DIV_STEP;
  localparam int DIVC_W     = $clog2(DIV_CYCLES);
  localparam logic [DIVC_W-1:0] DIV_LAST = DIVC_W'(DIV_CYCLES - 1);

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic [THR_W-1:0]          threshold;
    logic [TERMS_W-1:0]        term_limit;
  } cos_req_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] cosine;
    logic [TERMS_W-1:0]        terms_added;
    logic                      clipped;
  } cos_res_t;

  typedef struct packed {
    logic load;
    logic step;
  } unit_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [1:0] {
    U_IDLE,
    U_SQUARE,
    U_MUL,
    U_DIV
  } unit_state_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_ACCUM,
    S_FINISH
  } top_state_t;

endpackage

@@ design/tcos_term_unit.sv @@
// Term engine: squares the angle, then scales the term magnitude by x^2/((2n-1)(2n)).
module tcos_term_unit import tcos_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  unit_cmd_t                 cmd,
  input  logic signed [ANGLE_W-1:0] angle,
  input  logic [CNT_W-1:0]          term_idx,
  output unit_stat_t                stat,
  output logic [ACC_W-1:0]          mag
);

  unit_state_t             state;
  unit_state_t             state_next;
  logic [MUL_STEP_W-1:0]   step;
  logic [DIVC_W-1:0]       div_cnt;
  logic [ANGLE_W-1:0]      ax;
  logic [ACC_W-1:0]        x2;
  logic [ACC_W-1:0]        pp;
  logic [PROD_W-1:0]       acc;
  logic [PROD_W-1:0]       pp_shift;
  logic [D_W-1:0]          d;
  logic [D_W-1:0]          rem;
  logic [QUO_W-1:0]        quo;
  logic [MUL_W-1:0]        mul_a;
  logic [MUL_W-1:0]        mul_b;
  logic [ACC_W-1:0]        prod;
  logic [D_W-1:0]          rem_w;
  logic [QUO_W-1:0]        quo_w;
  logic [D_W:0]            trial;
  logic                    sat;
  logic [MUL_W-1:0]        two_n;

  // Shared multiplier
  assign prod  = ACC_W'(mul_a) * ACC_W'(mul_b);
  assign two_n = MUL_W'({term_idx, 1'b0});

  // Quotient overflows 63 bits when the top of the product reaches the divisor
  assign sat = (acc >> QSH) >= PROD_W'(pp[D_W-1:0]);

  // Align the registered partial product for accumulation
  always_comb begin
    pp_shift = '0;
    unique case (step)
      MUL_PP1: pp_shift = PROD_W'(pp);
      MUL_PP2: pp_shift = PROD_W'(pp) << MUL_W;
      MUL_PP3: pp_shift = PROD_W'(pp) << MUL_W;
      MUL_DIV: pp_shift = PROD_W'(pp) << (2 * MUL_W);
      default: pp_shift = '0;
    endcase
  end

  // Restoring division, a few quotient bits per cycle
  always_comb begin
    rem_w = rem;
    quo_w = quo;
    trial = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial = {rem_w, quo_w[QUO_W-1]};
      quo_w = {quo_w[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
        trial    = trial - {1'b0, d};
        quo_w[0] = 1'b1;
      end
      rem_w = trial[D_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      U_IDLE: begin
        if (cmd.load) begin
          state_next = U_SQUARE;
        end else if (cmd.step) begin
          state_next = U_MUL;
        end
      end
      U_SQUARE: state_next = U_IDLE;
      U_MUL: begin
        if (step == MUL_LAST) begin
          state_next = sat ? U_IDLE : U_DIV;
        end
      end
      U_DIV: begin
        if (div_cnt == DIV_LAST) begin
          state_next = U_IDLE;
        end
      end
      default: state_next = U_IDLE;
    endcase
  end

  // Outputs: status and multiplier operands
  always_comb begin
    stat.busy = (state != U_IDLE);
    stat.done = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      U_IDLE: begin
        stat.done = 1'b0;
      end
      U_SQUARE: begin
        mul_a     = ax;
        mul_b     = ax;
        stat.done = 1'b1;
      end
      U_MUL: begin
        stat.done = (step == MUL_LAST) && sat;
        unique case (step)
          MUL_PP0: begin
            mul_a = mag[MUL_W-1:0];
            mul_b = x2[MUL_W-1:0];
          end
          MUL_PP1: begin
            mul_a = mag[MUL_W-1:0];
            mul_b = x2[ACC_W-1:MUL_W];
          end
          MUL_PP2: begin
            mul_a = mag[ACC_W-1:MUL_W];
            mul_b = x2[MUL_W-1:0];
          end
          MUL_PP3: begin
            mul_a = mag[ACC_W-1:MUL_W];
            mul_b = x2[ACC_W-1:MUL_W];
          end
          MUL_DIV: begin
            mul_a = two_n - MUL_W'(1);
            mul_b = two_n;
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      U_DIV: begin
        stat.done = (div_cnt == DIV_LAST);
      end
      default: begin
        stat.done = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= U_IDLE;
      step    <= '0;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      step    <= (state == U_MUL) ? step + MUL_STEP_W'(1) : '0;
      div_cnt <= (state == U_DIV) ? div_cnt + DIVC_W'(1) : '0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      U_IDLE: begin
        if (cmd.load) begin
          ax  <= angle[ANGLE_W-1] ? ANGLE_W'(-angle) : angle;
          mag <= ACC_ONE;
        end
        if (cmd.step) begin
          acc <= '0;
        end
      end
      U_SQUARE: begin
        x2 <= prod;
      end
      U_MUL: begin
        pp  <= prod;
        acc <= acc + pp_shift;
        if (step == MUL_LAST) begin
          d   <= pp[D_W-1:0];
          rem <= D_W'(acc >> QSH);
          quo <= acc[2*FRAC_BITS +: QUO_W];
          if (sat) begin
            mag <= ACC_MAX;
          end
        end
      end
      U_DIV: begin
        rem <= rem_w;
        quo <= quo_w;
        if (div_cnt == DIV_LAST) begin
          mag <= ACC_W'(quo_w);
        end
      end
      default: begin
        pp <= pp;
      end
    endcase
  end

endmodule

@@ design/taylor_cos_series.sv @@
// Fixed-point cosine by Maclaurin series, one request at a time.
//
// Request channel (req_valid / req_stall / req): angle in signed Q3.28,
// a term-magnitude threshold in unsigned Q0.32 (zero turns off the early
// stop) and a term limit, clamped to MAX_TERMS. A request is taken when
// req_valid is high and req_stall is low; req_stall stays high from the
// cycle after acceptance until the result moves into the response register.
// Response channel (rsp_valid / rsp_stall / rsp): cosine in signed Q3.28,
// saturated with the clipped flag, and the number of terms summed.
// Each term after the first passes through the shared 32x32 multiplier
// (four partial products plus the divisor) and then through the 3-bit-per-
// cycle divider. A term whose scaled magnitude saturates skips the divider.
// A zero term limit goes straight to the finish state and answers with no
// terms summed. The block works on one request at a time; the next request
// is taken as soon as the previous result sits in the response register,
// even while rsp_stall holds it there.
// Reset clears the sequencers and the response valid; no request is taken
// while rst is high.
module taylor_cos_series import tcos_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  cos_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output cos_res_t rsp
);

  top_state_t              state;
  top_state_t              state_next;
  unit_cmd_t               cmd;
  unit_stat_t              stat;
  logic [ACC_W-1:0]        mag;
  logic                    accept;
  logic [CNT_W-1:0]        lim_in;
  logic [CNT_W-1:0]        limit;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        cnt_inc;
  logic [THR_W-1:0]        thr;
  logic                    neg;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] sum_next;
  logic [ACC_W:0]          tot;
  logic                    stop;
  logic                    rsp_load;
  logic signed [ACC_W-1:0] scaled;
  cos_res_t                res_next;

  assign accept  = req_valid && !req_stall;
  assign lim_in  = (32'(req.term_limit) > 32'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
                                                          : CNT_W'(req.term_limit);
  assign cnt_inc = cnt + CNT_W'(1);

  // Saturating add or subtract of the current term
  always_comb begin
    tot = neg ? ({sum[ACC_W-1], sum} - {1'b0, mag}) : ({sum[ACC_W-1], sum} + {1'b0, mag});
    if (tot[ACC_W] != tot[ACC_W-1]) begin
      sum_next = tot[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_next = tot[ACC_W-1:0];
    end
  end

  // Stop after a small term or at the limit
  assign stop = (mag < ACC_W'({thr, {THR_SHIFT{1'b0}}})) || (cnt_inc == limit);

  // Scale the sum to the output format and clamp
  always_comb begin
    scaled               = sum >>> OUT_SHIFT;
    res_next.terms_added = TERMS_W'(cnt);
    res_next.clipped     = (scaled > RES_HI) || (scaled < RES_LO);
    if (scaled > RES_HI) begin
      res_next.cosine = COS_HI;
    end else if (scaled < RES_LO) begin
      res_next.cosine = COS_LO;
    end else begin
      res_next.cosine = scaled[ANGLE_W-1:0];
    end
  end

  tcos_term_unit u_term (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .angle    (req.angle),
    .term_idx (cnt),
    .stat     (stat),
    .mag      (mag)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (lim_in == '0) ? S_FINISH : S_WAIT;
        end
      end
      S_WAIT: begin
        if (stat.done) begin
          state_next = S_ACCUM;
        end
      end
      S_ACCUM: begin
        state_next = stop ? S_FINISH : S_WAIT;
      end
      S_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req_stall = rst || (state != S_IDLE);
    cmd.load  = (state == S_IDLE) && accept && (lim_in != '0);
    cmd.step  = (state == S_ACCUM) && !stop;
    rsp_load  = (state == S_FINISH) && (!rsp_valid || !rsp_stall);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request capture, running sum and response register
  always_ff @(posedge clk) begin
    if (accept) begin
      thr   <= req.threshold;
      limit <= lim_in;
      sum   <= '0;
      neg   <= 1'b0;
      cnt   <= '0;
    end
    if (state == S_ACCUM) begin
      sum <= sum_next;
      cnt <= cnt_inc;
      if (cmd.step) begin
        neg <= ~neg;
      end
    end
    if (rsp_load) begin
      rsp <= res_next;
    end
  end

`ifndef SYNTH
  a_cmd_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.load || cmd.step) |-> !stat.busy)
    else $error("term unit commanded while busy");

  a_cnt_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) |-> (cnt <= limit))
    else $error("more terms summed than the limit");

  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_FINISH))
    else $error("response raised outside finish");
`endif

endmodule
